// File: sv/wsmv_pkg.sv
`default_nettype none

package wsmv_pkg;

  // field widths
  localparam int SYMBOL_W = 7;
  localparam int WINNER_W = 5;
  localparam int VOTES_W  = 7;
  localparam int STATUS_W = 2;

  // configuration port
  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_MIN_VOTES  = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd8;
  localparam logic [CFG_W-1:0] MIN_VOTES_RESET  = 7'd0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_WEAK = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  localparam logic signed [SYMBOL_W-1:0] SILENCE = '1;

  localparam int NUM_SYMBOLS_DEF = 32;
  localparam int MAX_WINDOW_DEF  = 64;

endpackage

`default_nettype wire

// File: sv/windowed_symbol_majority_vote.sv
// windowed majority vote over a stream of detected symbols
//
// input channel: in_valid / in_stall with symbol (signed, 0..NUM_SYMBOLS-1 valid,
// -1 silence, anything else invalid). one transaction per symbol.
// output channel: out_valid / out_stall with winner, votes and status, one
// transaction per completed window of window_len (0 as 1, max MAX_WINDOW) symbols.
// config port: cfg_write with cfg_index / cfg_data, to be written only while idle (the block does not enforce this).
//
// per-symbol counts live in a synchronous ram with a registered read. a symbol
// reads its count when accepted and, unless it ends its window, writes count+1
// back in the following cycle; a forwarding register covers back-to-back hits
// on the same symbol, and per-entry valid bits clear the whole table at once at
// a window end. throughput: one symbol per cycle while in_stall is low, set by
// the single read-modify-write of the count ram; a window's result goes to the
// output register as its last symbol leaves the update stage. when out_stall
// holds a result and the next window ends, the update stage holds its symbol
// and in_stall rises until the output register drains. reset clears the window
// state and loads window_len 8, min_votes 0; no clearing pass is needed.
`default_nettype none

module windowed_symbol_majority_vote #(
  parameter int NUM_SYMBOLS = wsmv_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_WINDOW  = wsmv_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wsmv_pkg::SYMBOL_W-1:0] symbol,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wsmv_pkg::WINNER_W-1:0]       winner,
  output logic [wsmv_pkg::VOTES_W-1:0]        votes,
  output logic [wsmv_pkg::STATUS_W-1:0]       status,
  input  logic                                cfg_write,
  input  logic [wsmv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wsmv_pkg::CFG_W-1:0]          cfg_data
);
  import wsmv_pkg::*;

  localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int POS_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = POS_W;
  localparam int LEN_W = (POS_W > CFG_W) ? POS_W : CFG_W;

  // configuration
  logic [CFG_W-1:0] window_len;
  logic [CFG_W-1:0] min_votes;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
      min_votes  <= MIN_VOTES_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_WINDOW_LEN) window_len <= cfg_data;
      if (cfg_index == REG_MIN_VOTES)  min_votes  <= cfg_data;
    end
  end

  logic [LEN_W-1:0] len_ext;
  logic [POS_W-1:0] eff_len;

  always_comb begin
    len_ext = LEN_W'(window_len);
    if (len_ext == '0) begin
      eff_len = POS_W'(1);
    end else if (len_ext > LEN_W'(MAX_WINDOW)) begin
      eff_len = POS_W'(MAX_WINDOW);
    end else begin
      eff_len = POS_W'(len_ext);
    end
  end

  // input decode and read stage
  logic             in_accept;
  logic             in_hit;
  logic             in_bad;
  logic [SYM_W-1:0] in_addr;

  assign in_accept = in_valid && !in_stall;
  assign in_hit    = (symbol >= 0) && (symbol < NUM_SYMBOLS);
  assign in_bad    = !in_hit && (symbol != SILENCE);
  assign in_addr   = SYM_W'(symbol[SYMBOL_W-2:0]);

  logic [CNT_W-1:0]       count_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] count_vld;
  logic [CNT_W-1:0]       rd_data;

  logic             s1_valid;
  logic             s1_hit;
  logic             s1_bad;
  logic [SYM_W-1:0] s1_addr;
  logic             s1_fire;
  logic             s1_last;

  always_ff @(posedge clk) begin
    if (in_accept && in_hit) rd_data <= count_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hit  <= in_hit;
      s1_bad  <= in_bad;
      s1_addr <= in_addr;
    end
  end

  // update stage
  logic [CNT_W-1:0] best_count;
  logic [SYM_W-1:0] best_symbol;
  logic [POS_W-1:0] position;
  logic             bad_seen;

  logic             fwd_valid;
  logic [SYM_W-1:0] fwd_addr;
  logic [CNT_W-1:0] fwd_cnt;

  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] best_count_next;
  logic [SYM_W-1:0] best_symbol_next;
  logic [POS_W-1:0] position_next;
  logic             bad_seen_next;
  logic             res_weak;

  always_comb begin
    // last write to this entry may not be in rd_data yet
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cnt_cur = fwd_cnt;
    end else if (count_vld[s1_addr]) begin
      cnt_cur = rd_data;
    end else begin
      cnt_cur = '0;
    end
    cnt_new = cnt_cur + CNT_W'(1);

    best_count_next  = best_count;
    best_symbol_next = best_symbol;
    if (s1_hit && (cnt_new > best_count)) begin
      best_count_next  = cnt_new;
      best_symbol_next = s1_addr;
    end
    bad_seen_next = bad_seen || s1_bad;
    position_next = position + POS_W'(1);
    s1_last       = position_next >= eff_len;
    res_weak      = (min_votes != '0) && (LEN_W'(best_count_next) < LEN_W'(min_votes));
  end

  assign s1_fire  = s1_valid && !(s1_last && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (s1_fire && s1_hit && !s1_last) count_mem[s1_addr] <= cnt_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_vld   <= '0;
      fwd_valid   <= 1'b0;
      best_count  <= '0;
      best_symbol <= '0;
      position    <= '0;
      bad_seen    <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        count_vld   <= '0;
        fwd_valid   <= 1'b0;
        best_count  <= '0;
        best_symbol <= '0;
        position    <= '0;
        bad_seen    <= 1'b0;
      end else begin
        if (s1_hit) begin
          count_vld[s1_addr] <= 1'b1;
          fwd_valid          <= 1'b1;
        end
        best_count  <= best_count_next;
        best_symbol <= best_symbol_next;
        position    <= position_next;
        bad_seen    <= bad_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_hit && !s1_last) begin
      fwd_addr <= s1_addr;
      fwd_cnt  <= cnt_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      if (bad_seen_next) begin
        winner <= '0;
        votes  <= '0;
        status <= STATUS_BAD;
      end else begin
        winner <= WINNER_W'(best_symbol_next);
        votes  <= VOTES_W'(best_count_next);
        status <= res_weak ? STATUS_WEAK : STATUS_OK;
      end
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position < POS_W'(MAX_WINDOW))
    else $error("window position out of range");

  a_best_le_pos: assert property (@(posedge clk) disable iff (rst)
    POS_W'(best_count) <= position)
    else $error("best count exceeds symbols taken");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> position == '0 && best_count == '0 && !bad_seen && count_vld == '0)
    else $error("window state not cleared at window end");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_BAD |-> winner == '0 && votes == '0)
    else $error("invalid window result carries a winner");

endmodule

`default_nettype wire

// File: sim/tb_windowed_symbol_majority_vote.sv
`timescale 1ns / 100ps

module tb_windowed_symbol_majority_vote;
  import wsmv_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic [WINNER_W-1:0] winner;
    logic [VOTES_W-1:0]  votes;
    status_t             status;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SYMBOL_W-1:0] symbol = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WINNER_W-1:0] winner;
  logic [VOTES_W-1:0] votes;
  logic [STATUS_W-1:0] status;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  int tally [NUM_SYMBOLS_DEF];
  int lead_count;
  logic [WINNER_W-1:0] lead_symbol;
  int taken;
  bit saw_invalid;
  logic [CFG_W-1:0] window_setting = WINDOW_LEN_RESET;
  logic [CFG_W-1:0] min_setting = MIN_VOTES_RESET;

  logic signed [SYMBOL_W-1:0] pending_symbols [$];
  window_result_t expected_windows [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_wanted = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int symbols_taken = 0;
  int windows_checked = 0;
  int weak_windows = 0;
  int bad_windows = 0;
  int input_stall_cycles = 0;

  int opening_symbols [24] = '{
    0, 31, 31, 0, -1, 5, 5, 0,
    -1, -1, -1, -1, -1, -1, -1, -1,
    63, -64, 32, -2, 3, 3, 3, 3
  };

  windowed_symbol_majority_vote uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .symbol(symbol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .winner(winner),
    .votes(votes),
    .status(status),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int window_span(input logic [CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return int'(setting);
  endfunction

  function automatic void clear_window();
    foreach (tally[k]) tally[k] = 0;
    lead_count = 0;
    lead_symbol = '0;
    taken = 0;
    saw_invalid = 1'b0;
  endfunction

  // counts one accepted symbol and queues the window verdict at its end
  function automatic void tally_symbol(input logic signed [SYMBOL_W-1:0] sym);
    window_result_t verdict;
    int s;
    s = int'(sym);
    if (s >= 0 && s < NUM_SYMBOLS_DEF) begin
      tally[s]++;
      if (tally[s] > lead_count) begin
        lead_count = tally[s];
        lead_symbol = WINNER_W'(s);
      end
    end else if (sym != SILENCE) begin
      saw_invalid = 1'b1;
    end
    taken++;
    if (taken >= window_span(window_setting)) begin
      if (saw_invalid) begin
        verdict.winner = '0;
        verdict.votes = '0;
        verdict.status = STATUS_BAD;
      end else begin
        verdict.winner = lead_symbol;
        verdict.votes = VOTES_W'(lead_count);
        verdict.status = (min_setting != 0 && lead_count < int'(min_setting)) ?
                         STATUS_WEAK : STATUS_OK;
      end
      expected_windows.push_back(verdict);
      clear_window();
    end
  endfunction

  function automatic logic signed [SYMBOL_W-1:0] random_symbol(input bit noisy,
                                                              input int favorite);
    int r;
    r = $urandom_range(99);
    if (noisy && r < 12) begin
      // invalid codes: 32..63 and -64..-2
      r = $urandom_range(94);
      return (r < 32) ? SYMBOL_W'(32 + r) : SYMBOL_W'(r - 96);
    end
    if (r < 22) return SILENCE;
    if (r < 72) return SYMBOL_W'((favorite + $urandom_range(2)) % NUM_SYMBOLS_DEF);
    return SYMBOL_W'($urandom_range(NUM_SYMBOLS_DEF - 1));
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  task automatic settle();
    while (pending_symbols.size() != 0 || in_valid || expected_windows.size() != 0)
      @(negedge clk);
    // a partial window may still be in flight with no result to wait for
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_WINDOW_LEN: window_setting = value;
      REG_MIN_VOTES: min_setting = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] floor,
                           input int count);
    int span;
    int favorite;
    bit noisy;
    settle();
    write_reg(REG_WINDOW_LEN, len);
    write_reg(REG_MIN_VOTES, floor);
    span = window_span(len);
    noisy = 1'b0;
    favorite = 0;
    @(negedge clk);
    for (int k = 0; k < count; k++) begin
      if (k % span == 0) begin
        noisy = ($urandom_range(5) == 0);
        favorite = $urandom_range(NUM_SYMBOLS_DEF - 1);
      end
      pending_symbols.push_back(random_symbol(noisy, favorite));
    end
  endtask

  // driver: input transactions, prediction on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tally_symbol(symbol);
        symbols_taken++;
      end
      if (in_valid && in_stall) input_stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (pending_symbols.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          symbol <= pending_symbols.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_wanted && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: output transactions against the oldest expectation
  always @(posedge clk) begin
    window_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_windows.size() == 0) begin
        report_mismatch($sformatf("unexpected result winner %0d votes %0d status %0d",
                                  winner, votes, status));
      end else begin
        want = expected_windows.pop_front();
        windows_checked++;
        if (want.status == STATUS_WEAK) weak_windows++;
        if (want.status == STATUS_BAD) bad_windows++;
        if (winner !== want.winner)
          report_mismatch($sformatf("window %0d winner %0d, expected %0d",
                                    windows_checked, winner, want.winner));
        if (votes !== want.votes)
          report_mismatch($sformatf("window %0d votes %0d, expected %0d",
                                    windows_checked, votes, want.votes));
        if (status !== want.status)
          report_mismatch($sformatf("window %0d status %0d, expected %0d",
                                    windows_checked, status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_windows.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_window();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 62;

    // reset config: ties, silence-only window, invalid codes at the field extremes
    @(negedge clk);
    foreach (opening_symbols[k]) pending_symbols.push_back(SYMBOL_W'(opening_symbols[k]));
    settle();
    write_reg(REG_UNUSED_A, '1);
    write_reg(REG_UNUSED_B, '0);

    run_phase(7'd0, 7'd0, 100);
    run_phase(7'd1, 7'd1, 80);
    hold_wanted = 1'b1;
    run_phase(7'd64, 7'd64, 200);

    send_idle_pct = 62;
    recv_idle_pct = 16;
    run_phase(7'd127, 7'd127, 200);
    run_phase(7'd5, 7'd3, 200);
    run_phase(CFG_W'($urandom_range(2, 20)), CFG_W'($urandom_range(10)), 300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(7'd16, 7'd0, 250);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(127)), 370);
    settle();

    $display("%0d symbols in, %0d windows checked (%0d weak, %0d with invalid symbols)",
             symbols_taken, windows_checked, weak_windows, bad_windows);
    $display("input held off for %0d cycles, %0d cycles total", input_stall_cycles,
             cycle_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/wsmv_pkg.sv
sv/windowed_symbol_majority_vote.sv
sim/tb_windowed_symbol_majority_vote.sv
